/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the busy readout queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset
`define ABRF_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("invariant violated");

// Consequent must hold in the cycle after the antecedent
`define ABRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/abrf_pkg.sv */
// ----------------------------------------------------------------------------
// abrf_pkg
// Types and constants shared by the busy readout queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package abrf_pkg;

  localparam int RAW_W  = 16;
  localparam int CNT_W  = 32;
  localparam int QD_W   = 10;
  localparam int CFG_W  = 24;
  localparam int CIDX_W = 2;

  localparam int DEF_QUEUE_DEPTH = 1024;
  localparam int DEF_WORD_BITS   = 16;
  localparam int OQ_DEPTH        = 4;

  localparam logic [7:0]  RST_SCK_HALF = 8'd4;
  localparam logic [15:0] RST_RESTART  = 16'd150;
  localparam logic [15:0] RST_GUARD    = 16'd900;
  localparam logic [23:0] RST_RETRY    = 24'd150000;

  localparam logic [CIDX_W-1:0] CFG_SCK_HALF = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_RESTART  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GUARD    = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_RETRY    = 2'd3;

  // One queued sample
  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic [CNT_W-1:0] seq;
    logic [CNT_W-1:0] stamp;
  } entry_t;

  // Per-tick status, registered so that it lines up with the queue read data
  typedef struct packed {
    logic             valid;
    logic             sck;
    logic             restart;
    logic             rv;
    logic [CNT_W-1:0] stored;
    logic [CNT_W-1:0] polls;
    logic [CNT_W-1:0] low_after;
    logic [CNT_W-1:0] dropped;
    logic [QD_W-1:0]  depth;
  } pend_t;

  // One complete result
  typedef struct packed {
    logic             sck;
    logic             restart;
    logic             rv;
    entry_t           sample;
    logic [CNT_W-1:0] stored;
    logic [CNT_W-1:0] polls;
    logic [CNT_W-1:0] low_after;
    logic [CNT_W-1:0] dropped;
    logic [QD_W-1:0]  depth;
  } res_t;

endpackage

`default_nettype wire

/* src/adc_busy_readout_fifo_core.sv */
// ----------------------------------------------------------------------------
// adc_busy_readout_fifo_core
// Busy-indicator readout of a serial converter with sample queue and stats.
// ----------------------------------------------------------------------------
// Each accepted request is one tick of the converter interface and yields one
// result. A new request is taken every clock cycle while the result queue has
// room. Results pass the registered read port of the sample memory, and a
// four-entry result queue lets the consumer stall without stopping the tick
// engine until that queue fills. No clearing pass runs after reset.
`default_nettype none

`include "assert_macros.svh"

module adc_busy_readout_fifo_core #(
  parameter int QUEUE_DEPTH = abrf_pkg::DEF_QUEUE_DEPTH,
  parameter int WORD_BITS   = abrf_pkg::DEF_WORD_BITS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           in_line_level,
  input  wire [31:0]                    in_ms_now,
  input  wire                           in_pop_request,
  input  wire                           in_clear_stats,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_sck_out,
  output logic                          out_restart_out,
  output logic                          out_read_valid,
  output logic [abrf_pkg::RAW_W-1:0]    out_read_raw,
  output logic [31:0]                   out_read_sequence,
  output logic [31:0]                   out_read_timestamp,
  output logic [31:0]                   out_stored_count,
  output logic [31:0]                   out_poll_count,
  output logic [31:0]                   out_low_after_count,
  output logic [31:0]                   out_dropped_count,
  output logic [abrf_pkg::QD_W-1:0]     out_queue_depth,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [abrf_pkg::CIDX_W-1:0]    cfg_index,
  input  wire [abrf_pkg::CFG_W-1:0]     cfg_data
);
  import abrf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH) + 1;

  logic          acc, wr_en, rd_en;
  logic [PW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;
  pend_t         pend;
  res_t          res, head;
  logic [CW-1:0] oq_count;

  // Take a request only when the result queue has room for everything in flight
  assign in_ready  = (oq_count + CW'(pend.valid)) < CW'(OQ_DEPTH);
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  abrf_front #(.QUEUE_DEPTH(QUEUE_DEPTH), .WORD_BITS(WORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc),
    .line_level(in_line_level), .ms_now(in_ms_now),
    .pop_request(in_pop_request), .clear_stats(in_clear_stats),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .pend(pend)
  );

  abrf_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ring (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Merge status with popped sample, zero when nothing was popped
  always_comb begin
    res = '{sck: pend.sck, restart: pend.restart, rv: pend.rv,
            sample: (pend.rv ? rd_data : '0), stored: pend.stored,
            polls: pend.polls, low_after: pend.low_after,
            dropped: pend.dropped, depth: pend.depth};
  end

  abrf_outq u_outq (
    .clk(clk), .rst_n(rst_n), .push(pend.valid), .push_data(res),
    .pop_valid(out_valid), .pop_ready(out_ready), .pop_data(head),
    .count(oq_count)
  );

  assign out_sck_out         = head.sck;
  assign out_restart_out     = head.restart;
  assign out_read_valid      = head.rv;
  assign out_read_raw        = head.sample.raw;
  assign out_read_sequence   = head.sample.seq;
  assign out_read_timestamp  = head.sample.stamp;
  assign out_stored_count    = head.stored;
  assign out_poll_count      = head.polls;
  assign out_low_after_count = head.low_after;
  assign out_dropped_count   = head.dropped;
  assign out_queue_depth     = head.depth;

  `ABRF_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !pend.valid || oq_count < CW'(OQ_DEPTH))

endmodule

`default_nettype wire

/* src/abrf_ring.sv */
// ----------------------------------------------------------------------------
// abrf_ring
// Sample storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module abrf_ring #(
  parameter int QUEUE_DEPTH = abrf_pkg::DEF_QUEUE_DEPTH
) (
  input  wire                               clk,
  input  wire                               wr_en,
  input  wire [$clog2(QUEUE_DEPTH)-1:0]     wr_addr,
  input  abrf_pkg::entry_t                  wr_data,
  input  wire                               rd_en,
  input  wire [$clog2(QUEUE_DEPTH)-1:0]     rd_addr,
  output abrf_pkg::entry_t                  rd_data
);
  import abrf_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  // Write new sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read popped sample
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/abrf_outq.sv */
// ----------------------------------------------------------------------------
// abrf_outq
// Small result queue that decouples the tick engine from the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module abrf_outq (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    push,
  input  abrf_pkg::res_t                         push_data,
  output logic                                   pop_valid,
  input  wire                                    pop_ready,
  output abrf_pkg::res_t                         pop_data,
  output logic [$clog2(abrf_pkg::OQ_DEPTH):0]    count
);
  import abrf_pkg::*;

  localparam int AW = $clog2(OQ_DEPTH);

  res_t          slot_r [OQ_DEPTH];
  logic [AW-1:0] head_r, tail_r;
  logic [AW:0]   count_r;
  logic          pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != '0);
  assign pop_data  = slot_r[head_r];
  assign count     = count_r;

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) tail_r <= tail_r + AW'(1);
      if (pop)  head_r <= head_r + AW'(1);
      count_r <= count_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  `ABRF_ASSERT_ALWAYS(a_oq_bound, clk, rst_n, count_r <= (AW+1)'(OQ_DEPTH))

endmodule

`default_nettype wire

/* src/abrf_front.sv */
// ----------------------------------------------------------------------------
// abrf_front
// Tick engine: readout sequencer, poll timers, ring pointers and counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module abrf_front #(
  parameter int QUEUE_DEPTH = abrf_pkg::DEF_QUEUE_DEPTH,
  parameter int WORD_BITS   = abrf_pkg::DEF_WORD_BITS
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               acc,
  input  wire                               line_level,
  input  wire [31:0]                        ms_now,
  input  wire                               pop_request,
  input  wire                               clear_stats,
  input  wire                               cfg_we,
  input  wire [abrf_pkg::CIDX_W-1:0]        cfg_index,
  input  wire [abrf_pkg::CFG_W-1:0]         cfg_data,
  output logic                              wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]    wr_addr,
  output abrf_pkg::entry_t                  wr_data,
  output logic                              rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]    rd_addr,
  output abrf_pkg::pend_t                   pend
);
  import abrf_pkg::*;

  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int PIW = $clog2(WORD_BITS + 2);

  typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW, PH_PULSE} phase_t;

  phase_t           phase_r, phase_nxt;
  logic [PIW-1:0]   pidx_r, pidx_nxt;
  logic [15:0]      ptim_r, ptim_nxt;
  logic [WORD_BITS-1:0] shift_r, shift_nxt;
  logic             store_r, store_nxt, by_edge_r, by_edge_nxt;
  logic [31:0]      stamp_r, stamp_nxt;
  logic             prev_r, prev_nxt, armed_r, armed_nxt;
  logic [31:0]      cyc_r, cyc_nxt, last_r, last_nxt, npoll_r, npoll_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt, wp_inc;
  logic [31:0]      c_st_r, c_st_nxt, c_po_r, c_po_nxt;
  logic [31:0]      c_lo_r, c_lo_nxt, c_dr_r, c_dr_nxt;
  logic [7:0]       sck_half_r;
  logic [15:0]      restart_r, guard_r;
  logic [23:0]      retry_r;
  pend_t            pend_r, pend_nxt;
  logic             edge_ok, rv;
  logic [31:0]      now, since_cap, since_poll;
  logic [PW:0]      diff;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Work out one tick
  always_comb begin
    phase_nxt = phase_r;   pidx_nxt = pidx_r;   ptim_nxt = ptim_r;
    shift_nxt = shift_r;   store_nxt = store_r; by_edge_nxt = by_edge_r;
    stamp_nxt = stamp_r;   prev_nxt = prev_r;   armed_nxt = armed_r;
    cyc_nxt = cyc_r;       last_nxt = last_r;   npoll_nxt = npoll_r;
    seq_nxt = seq_r;       wp_nxt = wp_r;       rp_nxt = rp_r;
    c_st_nxt = c_st_r;     c_po_nxt = c_po_r;   c_lo_nxt = c_lo_r;
    c_dr_nxt = c_dr_r;
    wr_en = 1'b0; wr_addr = wp_r; rd_en = 1'b0; rd_addr = rp_r;
    wr_data = '{raw: RAW_W'(shift_r), seq: seq_r, stamp: stamp_r};
    wp_inc = '0; rv = 1'b0; edge_ok = 1'b1;
    now = cyc_r; since_cap = '0; since_poll = '0;
    if (acc) begin
      // Clear queue and statistics
      if (clear_stats) begin
        wp_nxt = '0; rp_nxt = '0;
        c_st_nxt = '0; c_po_nxt = '0; c_lo_nxt = '0; c_dr_nxt = '0;
        seq_nxt = '0; last_nxt = now; npoll_nxt = now; armed_nxt = 1'b1;
        edge_ok = 1'b0;
      end
      // Pop the oldest sample
      if (pop_request && rp_nxt != wp_nxt) begin
        rv = 1'b1; rd_en = 1'b1; rd_addr = rp_nxt;
        rp_nxt = ptr_inc(rp_nxt);
      end
      // Advance readout sequencer
      since_cap  = now - last_nxt;
      since_poll = now - npoll_nxt;
      unique case (phase_r)
        PH_IDLE: begin
          if (edge_ok && prev_r && !line_level) begin
            phase_nxt = PH_HIGH; ptim_nxt = 16'd1; pidx_nxt = '0; shift_nxt = '0;
            store_nxt = 1'b1; by_edge_nxt = 1'b1; stamp_nxt = ms_now;
          end else if (line_level) begin
            armed_nxt = 1'b1;
          end else if (since_cap >= {16'd0, guard_r} && !since_poll[31]) begin
            c_po_nxt = c_po_nxt + 32'd1;
            phase_nxt = PH_HIGH; ptim_nxt = 16'd1; pidx_nxt = '0; shift_nxt = '0;
            store_nxt = armed_nxt; by_edge_nxt = 1'b0; stamp_nxt = ms_now;
          end
        end
        PH_HIGH: begin
          if (ptim_r >= {8'd0, sck_half_r}) begin
            phase_nxt = PH_LOW; ptim_nxt = 16'd1;
          end else begin
            ptim_nxt = ptim_r + 16'd1;
          end
        end
        PH_LOW: begin
          if (ptim_r >= {8'd0, sck_half_r}) begin
            if (pidx_r < PIW'(WORD_BITS)) begin
              shift_nxt = {shift_r[WORD_BITS-2:0], line_level};
            end
            pidx_nxt = pidx_r + PIW'(1);
            ptim_nxt = 16'd1;
            phase_nxt = (pidx_r >= PIW'(WORD_BITS)) ? PH_PULSE : PH_HIGH;
          end else begin
            ptim_nxt = ptim_r + 16'd1;
          end
        end
        PH_PULSE: begin
          if (ptim_r >= restart_r) begin
            last_nxt = now;
            if (!line_level) c_lo_nxt = c_lo_nxt + 32'd1;
            if (store_r) begin
              c_st_nxt = c_st_nxt + 32'd1;
              seq_nxt = seq_nxt + 32'd1;
              wp_inc = ptr_inc(wp_nxt);
              if (wp_inc == rp_nxt) begin
                c_dr_nxt = c_dr_nxt + 32'd1;
              end else begin
                wr_en = 1'b1; wr_addr = wp_nxt;
                wr_data = '{raw: RAW_W'(shift_r), seq: seq_nxt, stamp: stamp_r};
                wp_nxt = wp_inc;
              end
            end
            if (by_edge_r) begin
              armed_nxt = 1'b0; npoll_nxt = now + {16'd0, guard_r};
            end else if (line_level) begin
              armed_nxt = 1'b1; npoll_nxt = now;
            end else begin
              armed_nxt = 1'b0; npoll_nxt = now + {8'd0, retry_r};
            end
            phase_nxt = PH_IDLE; ptim_nxt = '0; store_nxt = 1'b0;
          end else begin
            ptim_nxt = ptim_r + 16'd1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
      prev_nxt = line_level;
      cyc_nxt = cyc_r + 32'd1;
    end
    // Assemble status for this tick
    diff = (wp_nxt >= rp_nxt) ? ({1'b0, wp_nxt} - {1'b0, rp_nxt})
                              : ({1'b0, wp_nxt} + (PW+1)'(QUEUE_DEPTH) - {1'b0, rp_nxt});
    pend_nxt = '{valid: acc, sck: (phase_nxt == PH_HIGH),
                 restart: (phase_nxt == PH_PULSE), rv: rv,
                 stored: c_st_nxt, polls: c_po_nxt, low_after: c_lo_nxt,
                 dropped: c_dr_nxt, depth: QD_W'(diff)};
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; pidx_r <= '0; ptim_r <= '0; shift_r <= '0;
      store_r <= 1'b0; by_edge_r <= 1'b0; stamp_r <= '0;
      prev_r <= 1'b1; armed_r <= 1'b1; cyc_r <= '0; last_r <= '0;
      npoll_r <= '0; seq_r <= '0; wp_r <= '0; rp_r <= '0;
      c_st_r <= '0; c_po_r <= '0; c_lo_r <= '0; c_dr_r <= '0;
      pend_r <= '0;
    end else begin
      phase_r <= phase_nxt; pidx_r <= pidx_nxt; ptim_r <= ptim_nxt;
      shift_r <= shift_nxt; store_r <= store_nxt; by_edge_r <= by_edge_nxt;
      stamp_r <= stamp_nxt; prev_r <= prev_nxt; armed_r <= armed_nxt;
      cyc_r <= cyc_nxt; last_r <= last_nxt; npoll_r <= npoll_nxt;
      seq_r <= seq_nxt; wp_r <= wp_nxt; rp_r <= rp_nxt;
      c_st_r <= c_st_nxt; c_po_r <= c_po_nxt; c_lo_r <= c_lo_nxt;
      c_dr_r <= c_dr_nxt; pend_r <= pend_nxt;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sck_half_r <= RST_SCK_HALF; restart_r <= RST_RESTART;
      guard_r <= RST_GUARD; retry_r <= RST_RETRY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCK_HALF: sck_half_r <= cfg_data[7:0];
        CFG_RESTART:  restart_r  <= cfg_data[15:0];
        CFG_GUARD:    guard_r    <= cfg_data[15:0];
        CFG_RETRY:    retry_r    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign pend = pend_r;

  `ABRF_ASSERT_NEXT(a_clear_no_drop, clk, rst_n, acc && clear_stats, c_dr_r == '0)

endmodule

`default_nettype wire

/* sim/tb_adc_busy_readout_fifo_core.sv */
// ----------------------------------------------------------------------------
// tb_adc_busy_readout_fifo_core
// Self-checking bench for the busy-indicator readout with sample queue.
// ----------------------------------------------------------------------------
// A request queue filled up front feeds a clocked driver. Register writes
// and drain points sit in the same queue, so they are only issued when no
// result is outstanding. Each accepted request runs through a tick model of
// the readout machine, queue and counters; the monitor compares every result
// with the oldest predicted one. Stimulus covers edge readouts, recovery
// polls, clears, pops and noise, under three idling patterns.
`timescale 1ns / 1ps
`default_nettype none

module tb_adc_busy_readout_fifo_core;
  import abrf_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW, PH_PULSE} phase_t;
  typedef enum logic [1:0] {OP_TICK, OP_CFG, OP_MODE, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t    kind;
    logic        lvl;
    logic [31:0] data;
    logic        pop;
    logic        clr;
    int          val;
  } op_t;

  typedef struct packed {
    logic        sck;
    logic        restart;
    logic        rv;
    logic [15:0] raw;
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [31:0] stored;
    logic [31:0] polls;
    logic [31:0] low_after;
    logic [31:0] dropped;
    logic [9:0]  depth;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_line_level = 1'b1, in_pop_request = 1'b0;
  logic in_clear_stats = 1'b0;
  logic [31:0] in_ms_now = '0;
  logic in_ready;
  logic out_valid, out_ready = 1'b0;
  logic out_sck_out, out_restart_out, out_read_valid;
  logic [RAW_W-1:0] out_read_raw;
  logic [31:0] out_read_sequence, out_read_timestamp, out_stored_count;
  logic [31:0] out_poll_count, out_low_after_count, out_dropped_count;
  logic [QD_W-1:0] out_queue_depth;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  adc_busy_readout_fifo_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_line_level(in_line_level),
    .in_ms_now(in_ms_now), .in_pop_request(in_pop_request),
    .in_clear_stats(in_clear_stats),
    .out_valid(out_valid), .out_ready(out_ready), .out_sck_out(out_sck_out),
    .out_restart_out(out_restart_out), .out_read_valid(out_read_valid),
    .out_read_raw(out_read_raw), .out_read_sequence(out_read_sequence),
    .out_read_timestamp(out_read_timestamp), .out_stored_count(out_stored_count),
    .out_poll_count(out_poll_count), .out_low_after_count(out_low_after_count),
    .out_dropped_count(out_dropped_count), .out_queue_depth(out_queue_depth),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state
  logic [7:0]  half_cfg;
  logic [15:0] restart_cfg, guard_cfg;
  logic [23:0] retry_cfg;
  phase_t      ph;
  int unsigned pulse_idx, ph_timer;
  logic [15:0] shift_word;
  logic        store_this, by_edge, prev_level, poll_armed;
  logic [31:0] capture_stamp, tick_count, last_capture_at, next_poll_at, seq_count;
  logic [9:0]  wr_ptr, rd_ptr;
  logic [15:0] raw_mem [1024];
  logic [31:0] seq_mem [1024];
  logic [31:0] stamp_mem [1024];
  logic [31:0] n_stored, n_polls, n_low_after, n_dropped;

  tick_result_t expected_results[$];
  op_t          request_q[$];
  int           send_idle_pct, recv_idle_pct;
  int           n_errors;
  int           settle;

  // Stimulus-side copy of the timing registers, to size readouts
  int sh_half = 4, sh_restart = 150, sh_guard = 900;

  task automatic start_readout(logic store, logic edge_start, logic [31:0] ms);
    ph = PH_HIGH;
    ph_timer = 1;
    pulse_idx = 0;
    shift_word = '0;
    store_this = store;
    by_edge = edge_start;
    capture_stamp = ms;
  endtask

  task automatic end_readout(logic lvl, logic [31:0] now);
    logic [9:0] nxt;
    last_capture_at = now;
    if (!lvl) n_low_after++;
    if (store_this) begin
      nxt = wr_ptr + 10'd1;
      n_stored++;
      seq_count++;
      if (nxt == rd_ptr) n_dropped++;
      else begin
        raw_mem[wr_ptr] = shift_word;
        seq_mem[wr_ptr] = seq_count;
        stamp_mem[wr_ptr] = capture_stamp;
        wr_ptr = nxt;
      end
    end
    if (by_edge) begin
      poll_armed = 1'b0;
      next_poll_at = now + guard_cfg;
    end else if (lvl) begin
      poll_armed = 1'b1;
      next_poll_at = now;
    end else begin
      poll_armed = 1'b0;
      next_poll_at = now + retry_cfg;
    end
    ph = PH_IDLE;
    ph_timer = 0;
    store_this = 1'b0;
  endtask

  // Advance the model by one tick and queue the resulting output
  task automatic predict_tick(logic lvl, logic [31:0] ms, logic pop, logic clr);
    tick_result_t r;
    logic [31:0] now;
    logic edge_ok;
    now = tick_count;
    edge_ok = 1'b1;
    r = '0;
    if (clr) begin
      wr_ptr = '0;
      rd_ptr = '0;
      {n_stored, n_polls, n_low_after, n_dropped} = '0;
      seq_count = '0;
      last_capture_at = now;
      next_poll_at = now;
      poll_armed = 1'b1;
      edge_ok = 1'b0;
    end
    if (pop && rd_ptr != wr_ptr) begin
      r.rv = 1'b1;
      r.raw = raw_mem[rd_ptr];
      r.seq = seq_mem[rd_ptr];
      r.stamp = stamp_mem[rd_ptr];
      rd_ptr++;
    end
    case (ph)
      PH_IDLE: begin
        if (edge_ok && prev_level && !lvl) start_readout(1'b1, 1'b1, ms);
        else if (lvl) poll_armed = 1'b1;
        else if ((now - last_capture_at) >= {16'd0, guard_cfg} &&
                 ((now - next_poll_at) >> 31) == 32'd0) begin
          n_polls++;
          start_readout(poll_armed, 1'b0, ms);
        end
      end
      PH_HIGH: begin
        if (ph_timer >= half_cfg) begin
          ph = PH_LOW;
          ph_timer = 1;
        end else ph_timer++;
      end
      PH_LOW: begin
        if (ph_timer >= half_cfg) begin
          if (pulse_idx < 16) shift_word = {shift_word[14:0], lvl};
          pulse_idx++;
          ph_timer = 1;
          ph = (pulse_idx >= 17) ? PH_PULSE : PH_HIGH;
        end else ph_timer++;
      end
      default: begin
        if (ph_timer >= restart_cfg) end_readout(lvl, now);
        else ph_timer++;
      end
    endcase
    prev_level = lvl;
    tick_count++;
    r.sck = (ph == PH_HIGH);
    r.restart = (ph == PH_PULSE);
    r.stored = n_stored;
    r.polls = n_polls;
    r.low_after = n_low_after;
    r.dropped = n_dropped;
    r.depth = wr_ptr - rd_ptr;
    expected_results.push_back(r);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] d);
    case (idx)
      CFG_SCK_HALF: half_cfg = d[7:0];
      CFG_RESTART:  restart_cfg = d[15:0];
      CFG_GUARD:    guard_cfg = d[15:0];
      default:      retry_cfg = d;
    endcase
  endtask

  // Request queue builders
  task automatic add_tick(logic lvl, logic [31:0] ms, logic pop, logic clr);
    op_t o;
    o.kind = OP_TICK; o.lvl = lvl; o.data = ms; o.pop = pop; o.clr = clr; o.val = 0;
    request_q.push_back(o);
  endtask

  task automatic add_ctl(op_kind_t k, int v, logic [31:0] d);
    op_t o;
    o.kind = k; o.lvl = 1'b0; o.data = d; o.pop = 1'b0; o.clr = 1'b0; o.val = v;
    request_q.push_back(o);
    if (k == OP_CFG) begin
      case (v)
        CFG_SCK_HALF: sh_half = (d[7:0] == 0) ? 1 : d[7:0];
        CFG_RESTART:  sh_restart = (d[15:0] == 0) ? 1 : d[15:0];
        CFG_GUARD:    sh_guard = d[15:0];
        default: ;
      endcase
    end
  endtask

  task automatic set_timing(int h, int rs, int g, int rt);
    add_ctl(OP_CFG, CFG_SCK_HALF, h);
    add_ctl(OP_CFG, CFG_RESTART, rs);
    add_ctl(OP_CFG, CFG_GUARD, g);
    add_ctl(OP_CFG, CFG_RETRY, rt);
  endtask

  function automatic logic chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // High, falling edge, random, all-one or all-zero bits for one full readout, then a last level
  task automatic edge_readout(int pop_pct, int clr_pct, int bits_mode);
    int n;
    logic b;
    n = 17 * 2 * sh_half + sh_restart + 1;
    add_tick(1'b1, $urandom, chance(pop_pct), 1'b0);
    add_tick(1'b0, $urandom, chance(pop_pct), 1'b0);
    for (int i = 0; i < n; i++) begin
      b = (bits_mode == 0) ? 1'($urandom_range(0, 1)) : (bits_mode == 1);
      add_tick(b, $urandom, chance(pop_pct), chance(clr_pct));
    end
  endtask

  // Hold the line low long enough for a few recovery polls
  task automatic low_run(int pop_pct, int clr_pct);
    int n;
    n = sh_guard + $urandom_range(1, 3) * (17 * 2 * sh_half + sh_restart + 4);
    for (int i = 0; i < n; i++)
      add_tick(chance(3), $urandom, chance(pop_pct), chance(clr_pct));
  endtask

  task automatic random_phase(int n_items);
    int start;
    start = request_q.size();
    while (request_q.size() - start < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: edge_readout(30, 1, 0);
        6, 7: low_run(30, 1);
        default:
          repeat (10) add_tick(1'($urandom_range(0, 1)), $urandom, chance(40), chance(5));
      endcase
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    logic nv, ncv, nl, np, nc;
    logic [31:0] nms;
    logic [CIDX_W-1:0] nidx;
    logic [CFG_W-1:0] ndata;
    op_t o;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      settle <= 0;
    end else begin
      nv = in_valid; ncv = cfg_valid; nl = in_line_level; np = in_pop_request;
      nc = in_clear_stats; nms = in_ms_now; nidx = cfg_index; ndata = cfg_data;
      if (in_valid && in_ready) begin
        predict_tick(in_line_level, in_ms_now, in_pop_request, in_clear_stats);
        nv = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        write_reg(cfg_index, cfg_data);
        ncv = 1'b0;
      end
      if (!nv && !ncv && request_q.size() > 0) begin
        o = request_q[0];
        case (o.kind)
          OP_MODE: begin
            send_idle_pct = (o.val == 0) ? 25 : (o.val == 1) ? 51 : 0;
            recv_idle_pct = (o.val == 0) ? 51 : (o.val == 1) ? 25 : 0;
            void'(request_q.pop_front());
          end
          OP_DRAIN: if (settle >= 4) void'(request_q.pop_front());
          OP_CFG: begin
            if (settle >= 4) begin
              ncv = 1'b1;
              nidx = CIDX_W'(o.val);
              ndata = o.data[CFG_W-1:0];
              void'(request_q.pop_front());
            end
          end
          default: begin
            if (!chance(send_idle_pct)) begin
              nv = 1'b1; nl = o.lvl; nms = o.data; np = o.pop; nc = o.clr;
              void'(request_q.pop_front());
            end
          end
        endcase
      end
      // Count quiet cycles with nothing outstanding
      settle <= (expected_results.size() == 0 && !in_valid && !cfg_valid) ? settle + 1 : 0;
      in_valid <= nv; in_line_level <= nl; in_ms_now <= nms;
      in_pop_request <= np; in_clear_stats <= nc;
      cfg_valid <= ncv; cfg_index <= nidx; cfg_data <= ndata;
    end
  end

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      n_errors++;
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    tick_result_t e;
    if (!rst_n) out_ready <= 1'b0;
    else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no prediction pending");
          n_errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("sck_out", e.sck, out_sck_out);
          check_field("restart_out", e.restart, out_restart_out);
          check_field("read_valid", e.rv, out_read_valid);
          check_field("read_raw", e.raw, out_read_raw);
          check_field("read_sequence", e.seq, out_read_sequence);
          check_field("read_timestamp", e.stamp, out_read_timestamp);
          check_field("stored_count", e.stored, out_stored_count);
          check_field("poll_count", e.polls, out_poll_count);
          check_field("low_after_count", e.low_after, out_low_after_count);
          check_field("dropped_count", e.dropped, out_dropped_count);
          check_field("queue_depth", e.depth, out_queue_depth);
        end
      end
      out_ready <= !chance(recv_idle_pct);
    end
  end

  // Watchdog on stalled handshakes
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= 5000) begin
      $display("adc_busy_readout_fifo_core: mismatch");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    half_cfg = RST_SCK_HALF; restart_cfg = RST_RESTART; guard_cfg = RST_GUARD;
    retry_cfg = RST_RETRY;
    ph = PH_IDLE; pulse_idx = 0; ph_timer = 0; shift_word = '0; store_this = 1'b0;
    by_edge = 1'b0; capture_stamp = '0; prev_level = 1'b1; poll_armed = 1'b1;
    tick_count = '0; last_capture_at = '0; next_poll_at = '0; seq_count = '0;
    wr_ptr = '0; rd_ptr = '0; {n_stored, n_polls, n_low_after, n_dropped} = '0;
    n_errors = 0; send_idle_pct = 25; recv_idle_pct = 51;

    // Directed: defaults, clear on an edge, pop on empty, field extremes
    add_ctl(OP_MODE, 0, 0);
    add_tick(1'b1, 32'h0, 1'b1, 1'b0);
    add_tick(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    add_tick(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_ctl(OP_DRAIN, 0, 0);
    set_timing(1, 1, 3, 5);
    edge_readout(0, 0, 1);
    edge_readout(0, 0, 2);
    low_run(50, 0);
    repeat (4) add_tick(1'b1, 32'h0, 1'b1, 1'b0);
    random_phase(220);

    // Hold off until all results are in, then run the largest settings briefly
    add_ctl(OP_DRAIN, 0, 0);
    set_timing(255, 65535, 65535, 24'hFF_FFFF);
    add_tick(1'b1, $urandom, 1'b0, 1'b0);
    add_tick(1'b0, $urandom, 1'b0, 1'b0);
    repeat (300) add_tick(1'($urandom_range(0, 1)), $urandom, chance(20), 1'b0);
    add_ctl(OP_DRAIN, 0, 0);
    set_timing(2, 3, 1, 1);
    add_ctl(OP_MODE, 1, 0);
    random_phase(220);

    // Queue several samples, then empty it
    add_ctl(OP_DRAIN, 0, 0);
    set_timing(1, 1, 1000, 40);
    add_tick(1'b1, 32'h0, 1'b0, 1'b1);
    repeat (4) edge_readout(0, 0, 0);
    repeat (6) add_tick(1'b1, $urandom, 1'b1, 1'b0);

    add_ctl(OP_DRAIN, 0, 0);
    set_timing(3, 7, 20, 60);
    add_ctl(OP_MODE, 2, 0);
    random_phase(220);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (request_q.size() != 0 || in_valid || cfg_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0)
      $display("adc_busy_readout_fifo_core: match");
    else
      $display("adc_busy_readout_fifo_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
